// ===== hw/rtl/toc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// toc_pkg
// Shared constants and types of the tile occupancy classifier.
// ----------------------------------------------------------------------------
package toc_pkg;

  localparam int DEF_MAX_TILE_COLS  = 64;
  localparam int DEF_MAX_TILE_SIDE  = 64;
  localparam int DEF_MAX_SCENE_SIDE = 4096;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int TILE_REG_W  = 7;
  localparam int SCENE_REG_W = 13;

  localparam int ROW_W   = 12;
  localparam int COL_W   = 6;
  localparam int COUNT_W = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TILE_WIDTH   = 2'd0,
    REG_TILE_HEIGHT  = 2'd1,
    REG_SCENE_WIDTH  = 2'd2,
    REG_SCENE_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [TILE_REG_W-1:0]  RST_TILE_WIDTH   = 7'd8;
  localparam logic [TILE_REG_W-1:0]  RST_TILE_HEIGHT  = 7'd8;
  localparam logic [SCENE_REG_W-1:0] RST_SCENE_WIDTH  = 13'd640;
  localparam logic [SCENE_REG_W-1:0] RST_SCENE_HEIGHT = 13'd480;

  // Per-pixel control that travels from the raster tracker to the accumulator.
  typedef struct packed {
    logic is_zero;
    logic active;
    logic tile_end;
    logic frame_end;
  } toc_flags_t;

endpackage : toc_pkg
`default_nettype wire

// ===== hw/rtl/toc_raster.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// toc_raster
// Tracks the raster position of the incoming pixel and its place in the tile
// grid, and flags zero pixels and the last pixel of each tile and of the image.
// ----------------------------------------------------------------------------
module toc_raster
  import toc_pkg::*;
#(
  parameter int MAX_TILE_COLS  = DEF_MAX_TILE_COLS,
  parameter int MAX_TILE_SIDE  = DEF_MAX_TILE_SIDE,
  parameter int MAX_SCENE_SIDE = DEF_MAX_SCENE_SIDE,
  localparam int TP_W = ($clog2(MAX_TILE_SIDE) > 0) ? $clog2(MAX_TILE_SIDE) : 1,
  localparam int TS_W = TP_W + 1,
  localparam int PP_W = $clog2(MAX_SCENE_SIDE),
  localparam int PS_W = PP_W + 1,
  localparam int CC_W = $clog2(MAX_TILE_COLS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic             advance,
  input  wire logic [7:0]       pixel,
  input  wire logic [TS_W-1:0]  tw,
  input  wire logic [TS_W-1:0]  th,
  input  wire logic [PS_W-1:0]  sw,
  input  wire logic [PS_W-1:0]  sh,
  output logic      [CC_W-1:0]  cur_col,
  output logic      [ROW_W-1:0] cur_row,
  output toc_flags_t            flags
);

  logic [PP_W-1:0] pixel_x;
  logic [PP_W-1:0] pixel_y;
  logic [TP_W-1:0] x_in_tile;
  logic [TP_W-1:0] y_in_tile;
  logic            line_end;
  logic            last_line;
  logic            end_x;
  logic            end_y;
  logic            x_tile_done;
  logic            y_tile_done;

  always_comb begin
    line_end    = (PS_W'(pixel_x) + PS_W'(1)) >= sw;
    last_line   = (PS_W'(pixel_y) + PS_W'(1)) >= sh;
    x_tile_done = (TS_W'(x_in_tile) + TS_W'(1)) >= tw;
    y_tile_done = (TS_W'(y_in_tile) + TS_W'(1)) >= th;
    end_x       = x_tile_done || line_end;
    end_y       = y_tile_done || last_line;
    flags.is_zero   = (pixel == 8'd0);
    flags.active    = cur_col < CC_W'(MAX_TILE_COLS);
    flags.tile_end  = end_x && end_y;
    flags.frame_end = line_end && last_line;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_x   <= '0;
      pixel_y   <= '0;
      x_in_tile <= '0;
      y_in_tile <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
    end else if (advance) begin
      if (line_end) begin
        pixel_x   <= '0;
        x_in_tile <= '0;
        cur_col   <= '0;
        if (last_line) begin
          pixel_y   <= '0;
          y_in_tile <= '0;
          cur_row   <= '0;
        end else begin
          pixel_y <= pixel_y + PP_W'(1);
          if (y_tile_done) begin
            y_in_tile <= '0;
            cur_row   <= cur_row + ROW_W'(1);
          end else begin
            y_in_tile <= y_in_tile + TP_W'(1);
          end
        end
      end else begin
        pixel_x <= pixel_x + PP_W'(1);
        if (x_tile_done) begin
          x_in_tile <= '0;
          if (cur_col < CC_W'(MAX_TILE_COLS)) begin
            cur_col <= cur_col + CC_W'(1);
          end
        end else begin
          x_in_tile <= x_in_tile + TP_W'(1);
        end
      end
    end
  end

endmodule : toc_raster
`default_nettype wire

// ===== hw/rtl/toc_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// toc_accum
// Holds one zero count per tile column in a synchronous memory, updates it by
// read, add and write back, and presents finished tiles in an output register.
// ----------------------------------------------------------------------------
module toc_accum
  import toc_pkg::*;
#(
  parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS,
  parameter int MAX_TILE_SIDE = DEF_MAX_TILE_SIDE,
  localparam int TP_W  = ($clog2(MAX_TILE_SIDE) > 0) ? $clog2(MAX_TILE_SIDE) : 1,
  localparam int TS_W  = TP_W + 1,
  localparam int HALF_W = 2 * TS_W,
  localparam int CC_W  = $clog2(MAX_TILE_COLS + 1),
  localparam int IDX_W = ($clog2(MAX_TILE_COLS) > 0) ? $clog2(MAX_TILE_COLS) : 1,
  localparam int CMP_W = (HALF_W > COUNT_W) ? HALF_W : COUNT_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               clear,
  input  wire logic               accept,
  input  wire logic [CC_W-1:0]    cur_col,
  input  wire logic [ROW_W-1:0]   cur_row,
  input  toc_flags_t              flags,
  input  wire logic [HALF_W-1:0]  half,
  output logic                    busy,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [ROW_W-1:0]   tile_row,
  output logic      [COL_W-1:0]   tile_col,
  output logic      [COUNT_W-1:0] zero_count,
  output logic                    passable,
  output logic                    frame_last
);

  logic [COUNT_W-1:0]       counts [MAX_TILE_COLS];
  logic [MAX_TILE_COLS-1:0] written;

  logic [IDX_W-1:0]   rd_idx;
  logic [COUNT_W-1:0] rd_data;
  logic               rd_written;
  logic               fwd_hit;
  logic [COUNT_W-1:0] fwd_data;

  logic               s1_valid;
  toc_flags_t         s1_flags;
  logic [IDX_W-1:0]   s1_idx;
  logic [ROW_W-1:0]   s1_row;

  logic               out_free;
  logic               s1_adv;
  logic               wr_en;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] wr_data;

  always_comb begin
    rd_idx   = cur_col[IDX_W-1:0];
    out_free = !out_valid || !out_stall;
    s1_adv   = s1_valid && (!(s1_flags.active && s1_flags.tile_end) || out_free);
    busy     = s1_valid && !s1_adv;
    wr_en    = s1_adv && s1_flags.active;
    if (fwd_hit) begin
      base = fwd_data;
    end else if (rd_written) begin
      base = rd_data;
    end else begin
      base = '0;
    end
    sum     = base + COUNT_W'(s1_flags.is_zero);
    wr_data = s1_flags.tile_end ? '0 : sum;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      counts[s1_idx] <= wr_data;
    end
    if (accept) begin
      rd_data  <= counts[rd_idx];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        written[s1_idx] <= 1'b1;
      end
      if (accept) begin
        rd_written <= written[rd_idx];
        fwd_hit    <= wr_en && (s1_idx == rd_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags;
      s1_idx   <= rd_idx;
      s1_row   <= cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en && s1_flags.tile_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1_flags.tile_end) begin
      tile_row   <= s1_row;
      tile_col   <= COL_W'(s1_idx);
      zero_count <= sum;
      passable   <= !(CMP_W'(sum) > CMP_W'(half));
      frame_last <= s1_flags.frame_end;
    end
  end

endmodule : toc_accum
`default_nettype wire

// ===== hw/rtl/tile_occupancy_classifier_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tile_occupancy_classifier_unit
// Counts zero pixels per tile of a raster map and classifies each finished
// tile as passable or blocked.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Word
//   in       input      in_valid / in_stall    pixel
//   out      output     out_valid / out_stall  tile_row, tile_col, zero_count,
//                                              passable, frame_last
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One pixel is taken every cycle while in_stall is low. A pixel reads its
// column count from the count memory at acceptance and writes it back from
// s1; a write and a read of the same column at one edge are forwarded. A
// finished tile enters the output register from s1. Reset and every
// configuration write restart the frame and clear all counts at once.
// in_stall rises only while a finished tile waits behind a stalled output word.
// ----------------------------------------------------------------------------
module tile_occupancy_classifier_unit
  import toc_pkg::*;
#(
  parameter int MAX_TILE_COLS  = DEF_MAX_TILE_COLS,
  parameter int MAX_TILE_SIDE  = DEF_MAX_TILE_SIDE,
  parameter int MAX_SCENE_SIDE = DEF_MAX_SCENE_SIDE
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             pixel,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [ROW_W-1:0]       tile_row,
  output logic      [COL_W-1:0]       tile_col,
  output logic      [COUNT_W-1:0]     zero_count,
  output logic                        passable,
  output logic                        frame_last
);

  localparam int TP_W   = ($clog2(MAX_TILE_SIDE) > 0) ? $clog2(MAX_TILE_SIDE) : 1;
  localparam int TS_W   = TP_W + 1;
  localparam int PS_W   = $clog2(MAX_SCENE_SIDE) + 1;
  localparam int CC_W   = $clog2(MAX_TILE_COLS + 1);
  localparam int HALF_W = 2 * TS_W;
  localparam int TC_W   = (TS_W > TILE_REG_W) ? TS_W : TILE_REG_W;
  localparam int SC_W   = (PS_W > SCENE_REG_W) ? PS_W : SCENE_REG_W;

  logic [TILE_REG_W-1:0]  tile_width;
  logic [TILE_REG_W-1:0]  tile_height;
  logic [SCENE_REG_W-1:0] scene_width;
  logic [SCENE_REG_W-1:0] scene_height;

  logic [TS_W-1:0]        tw;
  logic [TS_W-1:0]        th;
  logic [PS_W-1:0]        sw;
  logic [PS_W-1:0]        sh;
  logic [HALF_W-1:0]      half;
  logic [TC_W-1:0]        tw_ext;
  logic [TC_W-1:0]        th_ext;
  logic [SC_W-1:0]        sw_ext;
  logic [SC_W-1:0]        sh_ext;

  logic                   accept;
  logic [CC_W-1:0]        cur_col;
  logic [ROW_W-1:0]       cur_row;
  toc_flags_t             flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width   <= RST_TILE_WIDTH;
      tile_height  <= RST_TILE_HEIGHT;
      scene_width  <= RST_SCENE_WIDTH;
      scene_height <= RST_SCENE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TILE_WIDTH:   tile_width   <= cfg_data[TILE_REG_W-1:0];
        REG_TILE_HEIGHT:  tile_height  <= cfg_data[TILE_REG_W-1:0];
        REG_SCENE_WIDTH:  scene_width  <= cfg_data[SCENE_REG_W-1:0];
        REG_SCENE_HEIGHT: scene_height <= cfg_data[SCENE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are clamped; zero acts as one.
  always_comb begin
    tw_ext = TC_W'(tile_width);
    th_ext = TC_W'(tile_height);
    sw_ext = SC_W'(scene_width);
    sh_ext = SC_W'(scene_height);
    if (tw_ext == '0) begin
      tw = TS_W'(1);
    end else if (tw_ext > TC_W'(MAX_TILE_SIDE)) begin
      tw = TS_W'(MAX_TILE_SIDE);
    end else begin
      tw = tw_ext[TS_W-1:0];
    end
    if (th_ext == '0) begin
      th = TS_W'(1);
    end else if (th_ext > TC_W'(MAX_TILE_SIDE)) begin
      th = TS_W'(MAX_TILE_SIDE);
    end else begin
      th = th_ext[TS_W-1:0];
    end
    if (sw_ext == '0) begin
      sw = PS_W'(1);
    end else if (sw_ext > SC_W'(MAX_SCENE_SIDE)) begin
      sw = PS_W'(MAX_SCENE_SIDE);
    end else begin
      sw = sw_ext[PS_W-1:0];
    end
    if (sh_ext == '0) begin
      sh = PS_W'(1);
    end else if (sh_ext > SC_W'(MAX_SCENE_SIDE)) begin
      sh = PS_W'(MAX_SCENE_SIDE);
    end else begin
      sh = sh_ext[PS_W-1:0];
    end
    half = (HALF_W'(tw) * HALF_W'(th)) >> 1;
  end

  assign accept = in_valid && !in_stall;

  toc_raster #(
    .MAX_TILE_COLS  (MAX_TILE_COLS),
    .MAX_TILE_SIDE  (MAX_TILE_SIDE),
    .MAX_SCENE_SIDE (MAX_SCENE_SIDE)
  ) u_raster (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .advance (accept),
    .pixel   (pixel),
    .tw      (tw),
    .th      (th),
    .sw      (sw),
    .sh      (sh),
    .cur_col (cur_col),
    .cur_row (cur_row),
    .flags   (flags)
  );

  toc_accum #(
    .MAX_TILE_COLS (MAX_TILE_COLS),
    .MAX_TILE_SIDE (MAX_TILE_SIDE)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_we),
    .accept     (accept),
    .cur_col    (cur_col),
    .cur_row    (cur_row),
    .flags      (flags),
    .half       (half),
    .busy       (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tile_row   (tile_row),
    .tile_col   (tile_col),
    .zero_count (zero_count),
    .passable   (passable),
    .frame_last (frame_last)
  );

endmodule : tile_occupancy_classifier_unit
`default_nettype wire
